FILE: hw/rtl/gpd_pkg.sv
package gpd_pkg;

    localparam int SAMPLE_BITS         = 16;
    localparam int EXTRA_FRACTION_BITS = 8;

    localparam int IN_FRAC_BITS    = 6;
    localparam int GAIN_FRAC_BITS  = 8;
    localparam int SCALE_FRAC_BITS = 8;
    localparam int ALPHA_FRAC_BITS = 8;

    localparam int WEIGHT_W = 9;
    localparam int DEAD_W   = 15;
    localparam int GAIN_W   = 16;
    localparam int DELTA_W  = 8;

    localparam int STATE_W     = SAMPLE_BITS + EXTRA_FRACTION_BITS;
    localparam int TOTAL_SHIFT = IN_FRAC_BITS + EXTRA_FRACTION_BITS + GAIN_FRAC_BITS
                                 + SCALE_FRAC_BITS;
    localparam int CMP_W       = STATE_W + DEAD_W;

    // The accumulator holds the widest of the three products the shared multiplier forms.
    localparam int ACC_W = (STATE_W + GAIN_W + 1 > TOTAL_SHIFT + DELTA_W + 1) ?
                           STATE_W + GAIN_W + 1 : TOTAL_SHIFT + DELTA_W + 1;

    localparam int MPL_W = GAIN_W;
    localparam int CNT_W = $clog2(MPL_W + 1);

    localparam logic [CNT_W-1:0]    EMA_STEPS   = CNT_W'(WEIGHT_W);
    localparam logic [CNT_W-1:0]    GAIN_STEPS  = CNT_W'(GAIN_W);
    localparam logic [CNT_W-1:0]    SCALE_STEPS = CNT_W'(7);
    localparam logic [MPL_W-1:0]    SCALE_NUM   = MPL_W'(115);
    localparam logic [WEIGHT_W-1:0] ALPHA_MAX   = WEIGHT_W'(256);
    localparam logic [DELTA_W-1:0]  DELTA_LIMIT = DELTA_W'(127);

    localparam logic [WEIGHT_W-1:0] SMOOTHING_RESET = WEIGHT_W'(51);
    localparam logic [DEAD_W-1:0]   DEAD_BAND_RESET = DEAD_W'(32);
    localparam logic [GAIN_W-1:0]   GAIN_RESET      = GAIN_W'(256);

    typedef enum logic [1:0] {
        REG_SMOOTHING = 2'd0,
        REG_DEAD_BAND = 2'd1,
        REG_GAIN      = 2'd2,
        REG_MOTION    = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic                          sample_valid;
        logic signed [SAMPLE_BITS-1:0] rate_y;
        logic signed [SAMPLE_BITS-1:0] rate_z;
    } in_beat_t;

    typedef struct packed {
        logic signed [DELTA_W-1:0] delta_x;
        logic signed [DELTA_W-1:0] delta_y;
    } out_beat_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] smoothing_weight;
        logic [DEAD_W-1:0]   dead_band;
        logic [GAIN_W-1:0]   gain;
        logic                motion_enable;
    } cfg_t;

    typedef struct packed {
        logic                    start;
        logic signed [ACC_W-1:0] mcand;
        logic [MPL_W-1:0]        mplier;
        logic [CNT_W-1:0]        count;
    } mul_req_t;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] product;
    } mul_rsp_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } seq_status_t;

endpackage

FILE: hw/rtl/gpd_serial_mul.sv
module gpd_serial_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  gpd_pkg::mul_req_t req,
    output gpd_pkg::mul_rsp_t rsp
);
    import gpd_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] mcand_reg, mcand_next;
    logic [MPL_W-1:0]        mplier_reg, mplier_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        if (req.start) begin
            busy_next   = 1'b1;
            acc_next    = '0;
            mcand_next  = req.mcand;
            mplier_next = req.mplier;
            cnt_next    = req.count;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        cnt_reg    <= cnt_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

    // A new product must never be requested while one is still being formed.
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("multiplier started while busy");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("multiplier finished without having run");

endmodule

FILE: hw/rtl/gpd_seq.sv
module gpd_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  gpd_pkg::cfg_t        cfg,
    input  logic                 start,
    input  gpd_pkg::in_beat_t    sample,
    input  logic                 res_take,
    output gpd_pkg::seq_status_t status,
    output gpd_pkg::out_beat_t   res,
    output gpd_pkg::mul_req_t    mul_req,
    input  gpd_pkg::mul_rsp_t    mul_rsp
);
    import gpd_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_EMA_Y = 7'b0000010,
        ST_EMA_Z = 7'b0000100,
        ST_PREP  = 7'b0001000,
        ST_GAIN  = 7'b0010000,
        ST_SCALE = 7'b0100000,
        ST_HOLD  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [STATE_W-1:0]     fy_reg, fy_next;
    logic signed [STATE_W-1:0]     fz_reg, fz_next;
    logic signed [SAMPLE_BITS-1:0] rate_z_reg, rate_z_next;
    logic                          axis_z_reg, axis_z_next;
    logic                          zero_reg, zero_next;
    logic                          neg_reg, neg_next;
    logic                          sat_reg, sat_next;
    logic signed [DELTA_W-1:0]     dx_reg, dx_next;
    logic signed [DELTA_W-1:0]     dy_reg, dy_next;

    logic [MPL_W-1:0]          alpha;
    logic signed [STATE_W-1:0] f_sel;
    logic [STATE_W-1:0]        mag;
    logic [DELTA_W-1:0]        r_raw;
    logic [DELTA_W-1:0]        r_mag;
    logic signed [DELTA_W-1:0] delta;
    logic signed [STATE_W-1:0] step;

    function automatic logic signed [ACC_W-1:0] ema_diff(
        input logic signed [SAMPLE_BITS-1:0] x,
        input logic signed [STATE_W-1:0]     f
    );
        logic signed [STATE_W-1:0] xe;
        xe = STATE_W'(x) <<< EXTRA_FRACTION_BITS;
        return ACC_W'(xe) - ACC_W'(f);
    endfunction

    always_comb begin
        alpha = (cfg.smoothing_weight > ALPHA_MAX) ? MPL_W'(ALPHA_MAX)
                                                   : MPL_W'(cfg.smoothing_weight);
        f_sel = axis_z_reg ? fz_reg : fy_reg;
        mag   = f_sel[STATE_W-1] ? STATE_W'(-f_sel) : STATE_W'(f_sel);
        step  = STATE_W'($signed(mul_rsp.product) >>> ALPHA_FRAC_BITS);
        r_raw = mul_rsp.product[TOTAL_SHIFT +: DELTA_W];
        if (zero_reg) begin
            r_mag = '0;
        end else if (sat_reg || r_raw > DELTA_LIMIT) begin
            r_mag = DELTA_LIMIT;
        end else begin
            r_mag = r_raw;
        end
        delta = neg_reg ? $signed(r_mag) : -$signed(r_mag);
    end

    always_comb begin
        state_next  = state_reg;
        fy_next     = fy_reg;
        fz_next     = fz_reg;
        rate_z_next = rate_z_reg;
        axis_z_next = axis_z_reg;
        zero_next   = zero_reg;
        neg_next    = neg_reg;
        sat_next    = sat_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        mul_req     = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    rate_z_next    = sample.rate_z;
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = ema_diff(sample.rate_y, fy_reg);
                    mul_req.mplier = alpha;
                    mul_req.count  = EMA_STEPS;
                    state_next     = ST_EMA_Y;
                end
            end
            ST_EMA_Y: begin
                if (mul_rsp.done) begin
                    fy_next        = fy_reg + step;
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = ema_diff(rate_z_reg, fz_reg);
                    mul_req.mplier = alpha;
                    mul_req.count  = EMA_STEPS;
                    state_next     = ST_EMA_Z;
                end
            end
            ST_EMA_Z: begin
                if (mul_rsp.done) begin
                    fz_next     = fz_reg + step;
                    axis_z_next = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP: begin
                zero_next      = !cfg.motion_enable ||
                                 (CMP_W'(mag) <= (CMP_W'(cfg.dead_band) << EXTRA_FRACTION_BITS));
                neg_next       = f_sel[STATE_W-1];
                mul_req.start  = 1'b1;
                mul_req.mcand  = ACC_W'(mag);
                mul_req.mplier = cfg.gain;
                mul_req.count  = GAIN_STEPS;
                state_next     = ST_GAIN;
            end
            ST_GAIN: begin
                if (mul_rsp.done) begin
                    sat_next       = (mul_rsp.product >> (TOTAL_SHIFT + 1)) != '0;
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = ACC_W'(mul_rsp.product[TOTAL_SHIFT:0]);
                    mul_req.mplier = SCALE_NUM;
                    mul_req.count  = SCALE_STEPS;
                    state_next     = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (mul_rsp.done) begin
                    if (axis_z_reg) begin
                        dx_next     = delta;
                        axis_z_next = 1'b0;
                        state_next  = ST_PREP;
                    end else begin
                        dy_next    = delta;
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            fy_reg     <= '0;
            fz_reg     <= '0;
            axis_z_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            fy_reg     <= fy_next;
            fz_reg     <= fz_next;
            axis_z_reg <= axis_z_next;
        end
        rate_z_reg <= rate_z_next;
        zero_reg   <= zero_next;
        neg_reg    <= neg_next;
        sat_reg    <= sat_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
    end

    assign status.idle      = (state_reg == ST_IDLE);
    assign status.res_valid = (state_reg == ST_HOLD);
    assign res.delta_x      = dx_reg;
    assign res.delta_y      = dy_reg;

    // A finished result waits, unchanged, until the output register takes it.
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOLD && !res_take) |=> (state_reg == ST_HOLD && $stable(dx_reg)
                                                 && $stable(dy_reg)))
        else $error("result lost before it was taken");

    a_start_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_req.start |-> (state_reg != ST_HOLD && state_reg != ST_SCALE))
        else $error("multiplier started in a state that does not use it");

endmodule

FILE: hw/rtl/gyro_pointer_delta.sv
// Gyro pointer delta: turns gyro Y and Z rate samples into pointer movement counts.
// Input beats arrive on the s_ channel (valid/ready); a beat with sample_valid low is
// taken and dropped without touching the filter state. Every other beat updates both
// smoothing filters and yields one result beat of delta_x and delta_y on the m_ channel.
// Settings are written through the cfg_ port, one register per cycle. The user must
// write them only while the block is idle, which the block itself does not enforce;
// written so, they take effect for the next sample. All arithmetic runs through one
// shared shift-and-add multiplier that retires one multiplier bit per cycle: two
// filter updates of nine steps and, per axis, a gain product of sixteen steps and a
// scale product of seven. s_ready is high exactly when the sequencer is idle, so a
// sample is taken only after the last result has been handed to the output register.
// The result sits in an output register, so a stalled receiver holds back the next
// result only; the block takes the following sample meanwhile and waits with its
// finished result until the output register is free.
// Reset clears the filters, loads the default settings and empties the output register.
module gyro_pointer_delta (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gpd_pkg::in_beat_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output gpd_pkg::out_beat_t  m_data,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_wdata
);
    import gpd_pkg::*;

    cfg_t        cfg_reg, cfg_next;
    logic        m_valid_reg, m_valid_next;
    out_beat_t   m_data_reg, m_data_next;
    logic        start;
    logic        res_take;
    seq_status_t seq_status;
    out_beat_t   seq_res;
    mul_req_t    mul_req;
    mul_rsp_t    mul_rsp;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (reg_index_t'(cfg_index))
                REG_SMOOTHING: cfg_next.smoothing_weight = cfg_wdata[WEIGHT_W-1:0];
                REG_DEAD_BAND: cfg_next.dead_band        = cfg_wdata[DEAD_W-1:0];
                REG_GAIN:      cfg_next.gain             = cfg_wdata[GAIN_W-1:0];
                REG_MOTION:    cfg_next.motion_enable    = cfg_wdata[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    assign s_ready  = seq_status.idle;
    assign start    = s_valid && s_ready && s_data.sample_valid;
    assign res_take = seq_status.res_valid && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_take) begin
            m_valid_next = 1'b1;
            m_data_next  = seq_res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.smoothing_weight <= SMOOTHING_RESET;
            cfg_reg.dead_band        <= DEAD_BAND_RESET;
            cfg_reg.gain             <= GAIN_RESET;
            cfg_reg.motion_enable    <= 1'b1;
            m_valid_reg              <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    gpd_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .start    (start),
        .sample   (s_data),
        .res_take (res_take),
        .status   (seq_status),
        .res      (seq_res),
        .mul_req  (mul_req),
        .mul_rsp  (mul_rsp)
    );

    gpd_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    // A result handed over by the sequencer appears as an output beat in the next cycle.
    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        res_take |=> (m_valid_reg && m_data_reg == $past(seq_res)))
        else $error("result not loaded into the output register");

endmodule
